### rtl/core/least_loaded_job_dispatcher_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the least-loaded job dispatcher
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LEAST_LOADED_JOB_DISPATCHER_UNIT_DEFINES_SVH
`define LEAST_LOADED_JOB_DISPATCHER_UNIT_DEFINES_SVH

// Antecedent and consequent checked in the same cycle.
`define LLJD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LLJD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/lljd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lljd_pkg
// Widths, limits and beat types shared by the job dispatcher modules.
// ----------------------------------------------------------------------------
package lljd_pkg;

  localparam int DUR_W    = 16;
  localparam int CFG_W    = 5;
  localparam int SERVER_W = 4;
  localparam int LOAD_W   = 32;
  localparam int WAIT_W   = 48;

  localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};
  localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

  // Server count after reset.
  localparam logic [CFG_W-1:0] SERVERS_RESET = 5'd16;

  // Job queue between front and back; depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int RES_W       = SERVER_W + LOAD_W + WAIT_W + LOAD_W;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  // One queued job.
  typedef struct packed {
    logic [DUR_W-1:0] duration;
    logic             new_batch;
  } job_t;

  // One result; the first member lands in the highest bits.
  typedef struct packed {
    logic [LOAD_W-1:0]   makespan;
    logic [WAIT_W-1:0]   total_wait;
    logic [LOAD_W-1:0]   start_time;
    logic [SERVER_W-1:0] server;
  } result_t;

endpackage

### rtl/core/lljd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lljd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lljd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/lljd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lljd_front
// Accepts job beats, unpacks duration and batch flag, and queues them.
// ----------------------------------------------------------------------------
module lljd_front
  import lljd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_valid,
  output logic             s_ready,
  input  logic [DUR_W-1:0] s_duration,
  input  logic             s_new_batch,
  output logic             q_valid,
  output job_t             q_item,
  input  logic             q_pop
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  // Queue status and handshakes.
  assign s_ready = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];
  assign push    = s_valid && s_ready;
  assign pop     = q_pop && q_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{duration: s_duration, new_batch: s_new_batch};
    end
  end

endmodule

### rtl/core/lljd_back.sv
`timescale 1ns / 1ps
`include "least_loaded_job_dispatcher_unit_defines.svh"
// ----------------------------------------------------------------------------
// lljd_back
// Takes one queued job at a time, scans the server loads for the target,
// updates load, wait total and makespan, and holds the result beat.
// ----------------------------------------------------------------------------
module lljd_back
  import lljd_pkg::*;
#(
  parameter int MAX_SERVERS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] servers_in_use,
  input  logic             q_valid,
  input  job_t             q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output result_t          out_data
);

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W = $clog2(MAX_SERVERS + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECIDE = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_WAIT   = 5'b01000,
    ST_WRITE  = 5'b10000
  } state_t;

  state_t                   state;
  job_t                     cur;
  logic [CNT_W-1:0]         k;
  logic [CNT_W-1:0]         k_m1;
  logic [CNT_W-1:0]         jobs_seen;
  logic [WAIT_W-1:0]        wait_sum;
  logic [LOAD_W-1:0]        max_load;
  logic [MAX_SERVERS-1:0]   vld;
  logic [IDX_W-1:0]         scan_idx;
  logic [IDX_W-1:0]         scan_end;
  logic                     scan_first;
  logic                     in_order;
  logic                     rd_tag_v;
  logic                     rd_tag_first;
  logic [IDX_W-1:0]         rd_tag_idx;
  logic                     rd_vld;
  logic [LOAD_W-1:0]        ram_rdata;
  logic [LOAD_W-1:0]        rd_load;
  logic [LOAD_W-1:0]        best;
  logic [IDX_W-1:0]         best_idx;
  logic                     out_load;
  logic [LOAD_W:0]          load_sum;
  logic [LOAD_W-1:0]        new_load;
  logic [WAIT_W:0]          wait_add;
  logic [WAIT_W-1:0]        wait_next;
  logic [LOAD_W-1:0]        max_next;

  // Effective server count: zero acts as one, large values clamp.
  always_comb begin
    if (servers_in_use == '0) begin
      k = CNT_W'(1);
    end else if (int'(servers_in_use) > MAX_SERVERS) begin
      k = CNT_W'(MAX_SERVERS);
    end else begin
      k = CNT_W'(servers_in_use);
    end
  end
  assign k_m1 = k - CNT_W'(1);

  // Handshakes toward the queue and the output register.
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign out_load = (state == ST_WRITE) && (!out_valid || out_ready);

  // Loads never written in this batch read as zero.
  assign rd_load = rd_vld ? ram_rdata : '0;

  // Saturating arithmetic for the chosen server.
  assign load_sum  = {1'b0, best} + (LOAD_W + 1)'(cur.duration);
  assign new_load  = load_sum[LOAD_W] ? LOAD_MAX : load_sum[LOAD_W-1:0];
  assign wait_add  = {1'b0, wait_sum} + (WAIT_W + 1)'(best);
  assign wait_next = wait_add[WAIT_W] ? WAIT_MAX : wait_add[WAIT_W-1:0];
  assign max_next  = (new_load > max_load) ? new_load : max_load;

  lljd_ram #(
    .WIDTH (LOAD_W),
    .DEPTH (MAX_SERVERS)
  ) u_load_ram (
    .clk   (clk),
    .we    (out_load),
    .waddr (best_idx),
    .wdata (new_load),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  // Read tag pipeline and running minimum; strict compare keeps lowest index.
  always_ff @(posedge clk) begin
    rd_vld       <= vld[scan_idx];
    rd_tag_idx   <= scan_idx;
    rd_tag_first <= scan_first;
    if (rd_tag_v && (rd_tag_first || (rd_load < best))) begin
      best     <= rd_load;
      best_idx <= rd_tag_idx;
    end
  end

  // Sequencer and batch state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      jobs_seen <= '0;
      wait_sum  <= '0;
      max_load  <= '0;
      vld       <= '0;
      rd_tag_v  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_tag_v <= (state == ST_SCAN);
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_item.new_batch) begin
              jobs_seen <= '0;
              wait_sum  <= '0;
              max_load  <= '0;
              vld       <= '0;
            end
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (jobs_seen < k) begin
            scan_idx <= jobs_seen[IDX_W-1:0];
            scan_end <= jobs_seen[IDX_W-1:0];
            in_order <= 1'b1;
          end else begin
            scan_idx <= '0;
            scan_end <= k_m1[IDX_W-1:0];
            in_order <= 1'b0;
          end
          scan_first <= 1'b1;
          state      <= ST_SCAN;
        end
        ST_SCAN: begin
          scan_first <= 1'b0;
          if (scan_idx == scan_end) begin
            state <= ST_WAIT;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_WAIT: begin
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          if (out_load) begin
            vld[best_idx] <= 1'b1;
            wait_sum      <= wait_next;
            max_load      <= max_next;
            out_valid     <= 1'b1;
            if (in_order) begin
              jobs_seen <= jobs_seen + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Current job and result payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (out_load) begin
      out_data.server     <= SERVER_W'(best_idx);
      out_data.start_time <= best;
      out_data.total_wait <= wait_next;
      out_data.makespan   <= max_next;
    end
  end

  `LLJD_ASSERT_SAME(a_write_in_range, clk, rst, out_load, (CNT_W'(best_idx) < k), "load write outside active servers")
  `LLJD_ASSERT_NEXT(a_batch_clears, clk, rst, (q_pop && q_item.new_batch), ((jobs_seen == '0) && (wait_sum == '0) && (vld == '0)), "new batch did not clear state")
  `LLJD_ASSERT_NEXT(a_wait_covers_start, clk, rst, out_load, (out_data.total_wait >= WAIT_W'(out_data.start_time)), "wait total below start time")
  `LLJD_ASSERT_NEXT(a_span_covers_start, clk, rst, out_load, (out_data.makespan >= out_data.start_time), "makespan below start time")
  `LLJD_ASSERT_SAME(a_seen_bounded, clk, rst, 1'b1, (jobs_seen <= CNT_W'(MAX_SERVERS)), "job count beyond server count")

endmodule

### rtl/core/least_loaded_job_dispatcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_job_dispatcher_unit
// Greedy least-loaded job dispatcher with a streaming job input and result
// output.
// ----------------------------------------------------------------------------
// Each job beat carries a duration; the first K jobs of a batch go to servers
// 0..K-1 in order and every later job goes to the server with the smallest
// load, lowest index on a tie. A job with tuser set starts a new batch and
// clears all loads and totals first. Loads, the wait total and the makespan
// saturate. Jobs are handled one at a time: an in-order job reads only its own
// server's load and a least-loaded job scans all K loads through the single
// read port of the load RAM. A two-beat input queue and the output register
// let both sides stall on their own. The server count is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, as the
// block does not enforce this. 0 acts as 1; values above MAX_SERVERS act as MAX_SERVERS.
// ----------------------------------------------------------------------------
module least_loaded_job_dispatcher_unit
  import lljd_pkg::*;
#(
  parameter int MAX_SERVERS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration: servers_in_use
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata,
  // Job input
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [DUR_W-1:0]       s_axis_tdata,  // [15:0] duration
  input  logic                   s_axis_tuser,  // [0] new_batch
  // Result output
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [3:0] server, [35:4] start_time,
                                                // [83:36] total_wait,
                                                // [115:84] makespan, rest zero
);

  logic [CFG_W-1:0] servers_in_use;
  logic             q_valid;
  job_t             q_item;
  logic             q_pop;
  result_t          res;

  // Server count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      servers_in_use <= SERVERS_RESET;
    end else if (cfg_we) begin
      servers_in_use <= cfg_wdata;
    end
  end

  lljd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_valid     (s_axis_tvalid),
    .s_ready     (s_axis_tready),
    .s_duration  (s_axis_tdata),
    .s_new_batch (s_axis_tuser),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  lljd_back #(
    .MAX_SERVERS (MAX_SERVERS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .servers_in_use (servers_in_use),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_data       (res)
  );

  // Result fields packed from the lowest bit up, zero padded to whole bytes.
  assign m_axis_tdata = OUT_TDATA_W'(res);

endmodule
